// ===== rtl/chained_hash_map_macros.svh =====
// assertion macros used by the checker file
// depends on nothing; each macro expects clk and rst_n in scope
`ifndef CHAINED_HASH_MAP_MACROS_SVH
`define CHAINED_HASH_MAP_MACROS_SVH

// same-cycle implication
`define CHM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/chm_pkg.sv =====
// shared types and constants of the chained hash map
// no dependencies
`timescale 1ns / 1ps

package chm_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned BC_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_VALUE   = 2'd1;

  localparam logic [BC_W-1:0]    BUCKET_COUNT_RST = 9'd64;
  localparam logic [VALUE_W-1:0] NULL_VALUE_RST   = 32'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_HEAD_RD,
    ST_HEAD,
    ST_WALK,
    ST_ENT,
    ST_POP,
    ST_DONE
  } chm_state_t;

endpackage

// ===== rtl/chm_if.sv =====
// channel interfaces: request, result and register write
// depends on chm_pkg
`timescale 1ns / 1ps

interface chm_req_if;
  logic                        valid;
  logic                        ready;
  logic [chm_pkg::REQ_W-1:0]   req_type;
  logic [chm_pkg::KEY_W-1:0]   key;
  logic [chm_pkg::VALUE_W-1:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface chm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [chm_pkg::VALUE_W-1:0] read_value;
  logic                        found;
  logic                        full_error;
  logic [chm_pkg::COUNT_W-1:0] entry_count;
  modport source (output valid, read_value, found, full_error, entry_count, input ready);
  modport sink   (input valid, read_value, found, full_error, entry_count, output ready);
endinterface

interface chm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [chm_pkg::CFG_IDX_W-1:0] index;
  logic [chm_pkg::VALUE_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/chm_ram.sv =====
// single-port-write, single-port-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module chm_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/chm_div.sv =====
// restoring remainder unit, one dividend bit per cycle
// no dependencies
`timescale 1ns / 1ps

module chm_div #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] shift_r, shift_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    trial     = {rem_r, shift_r[DIVIDEND_W-1]};
    if (start) begin
      shift_nxt = dividend;
      rem_nxt   = '0;
      dvs_nxt   = divisor;
      cnt_nxt   = CNT_W'(DIVIDEND_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        trial = trial - {1'b0, dvs_r};
      end
      rem_nxt   = trial[DIVISOR_W-1:0];
      shift_nxt = shift_r << 1;
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/chained_hash_map.sv =====
// chained hash map: one request at a time; a put that misses takes a new entry from the free
// pool and links it at the head of its chain; a nop skips the hash and goes to the result
// a result beat held by the sink stalls the map until it is taken; the bucket index comes from
// a bit-serial remainder unit; the next request can be accepted in the cycle after the result loads
// reset (synchronous, active low) empties all buckets, refills the free pool,
// zeroes the entry count and restores bucket_count 64, null_value 0; no clearing pass
`timescale 1ns / 1ps

module chained_hash_map #(
  parameter int unsigned MAX_BUCKETS  = 256,
  parameter int unsigned POOL_ENTRIES = 256,
  parameter int unsigned KEY_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  chm_req_if.sink   in_ch,
  chm_rsp_if.source out_ch,
  chm_cfg_if.sink   cfg_ch
);

  // entry address, link (with an extra nil code), bucket address, bucket count widths
  localparam int unsigned AW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned LW   = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NB_W = $clog2(MAX_BUCKETS + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  chm_pkg::chm_state_t state_r, state_nxt;

  // configuration registers
  logic [chm_pkg::BC_W-1:0]    bc_r;
  logic [chm_pkg::VALUE_W-1:0] null_r;

  // request under work
  logic [chm_pkg::REQ_W-1:0]   req_r, req_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [chm_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [BW-1:0]               b_r, b_nxt;
  logic [LW-1:0]               head_r, head_nxt;
  logic [LW-1:0]               cur_r, cur_nxt;
  logic [LW-1:0]               prev_r, prev_nxt;
  logic [LW-1:0]               steps_r, steps_nxt;

  // pool bookkeeping: free stack top, lowest top ever reached, stored entries
  logic [LW-1:0]               ft_r, ft_nxt;
  logic [LW-1:0]               low_r, low_nxt;
  logic [LW-1:0]               cnt_r, cnt_nxt;
  logic [MAX_BUCKETS-1:0]      hvalid_r, hvalid_nxt;

  // result being built and result register
  logic [chm_pkg::VALUE_W-1:0] rd_r, rd_nxt;
  logic                        fnd_r, fnd_nxt;
  logic                        full_r, full_nxt;
  logic                        ov_r, ov_nxt;
  logic [chm_pkg::VALUE_W-1:0] ord_r, ord_nxt;
  logic                        ofnd_r, ofnd_nxt;
  logic                        ofull_r, ofull_nxt;
  logic [chm_pkg::COUNT_W-1:0] ocnt_r, ocnt_nxt;

  // key hash and effective bucket count
  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] hash;
  logic [NB_W-1:0]     n_eff;
  logic                div_start;
  logic                div_done;
  logic [NB_W-1:0]     div_rem;

  // memory ports
  logic              h_we, h_re;
  logic [BW-1:0]     h_waddr;
  logic [LW-1:0]     h_wdata, h_rdata;
  logic              e_re;
  logic [AW-1:0]     e_raddr;
  logic              k_we;
  logic [AW-1:0]     k_waddr;
  logic [KEY_BITS-1:0] k_rdata;
  logic              v_we;
  logic [AW-1:0]     v_waddr;
  logic [chm_pkg::VALUE_W-1:0] v_wdata, v_rdata;
  logic              l_we;
  logic [AW-1:0]     l_waddr;
  logic [LW-1:0]     l_wdata, l_rdata;
  logic              s_we, s_re;
  logic [AW-1:0]     s_waddr, s_raddr, s_wdata, s_rdata;
  logic [LW-1:0]     ft_dec;
  logic [AW-1:0]     new_e;

  assign key_in = KEY_BITS'(in_ch.key);
  assign hash   = key_in ^ (key_in >> 1);

  // zero acts as one, above the bucket array acts as its size
  always_comb begin
    if (bc_r == '0) begin
      n_eff = NB_W'(1);
    end else if (32'(bc_r) > 32'(MAX_BUCKETS)) begin
      n_eff = NB_W'(MAX_BUCKETS);
    end else begin
      n_eff = NB_W'(bc_r);
    end
  end

  assign ft_dec = ft_r - 1'b1;
  // slots below the low-water mark were never pushed, so their entry index is derived from the slot
  assign new_e  = (ft_r < low_r) ? AW'(LW'(POOL_ENTRIES - 1) - ft_r) : s_rdata;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    b_nxt      = b_r;
    head_nxt   = head_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    steps_nxt  = steps_r;
    ft_nxt     = ft_r;
    low_nxt    = low_r;
    cnt_nxt    = cnt_r;
    hvalid_nxt = hvalid_r;
    rd_nxt     = rd_r;
    fnd_nxt    = fnd_r;
    full_nxt   = full_r;
    ov_nxt     = ov_r;
    ord_nxt    = ord_r;
    ofnd_nxt   = ofnd_r;
    ofull_nxt  = ofull_r;
    ocnt_nxt   = ocnt_r;
    div_start  = 1'b0;
    h_we = 1'b0; h_re = 1'b0; h_waddr = b_r; h_wdata = NIL;
    e_re = 1'b0; e_raddr = cur_r[AW-1:0];
    k_we = 1'b0; k_waddr = new_e;
    v_we = 1'b0; v_waddr = new_e; v_wdata = val_r;
    l_we = 1'b0; l_waddr = new_e; l_wdata = head_r;
    s_we = 1'b0; s_re = 1'b0; s_waddr = ft_r[AW-1:0]; s_raddr = ft_dec[AW-1:0];
    s_wdata = cur_r[AW-1:0];

    // result beat leaves the output register
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      chm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt  = in_ch.req_type;
          key_nxt  = key_in;
          val_nxt  = in_ch.value;
          rd_nxt   = null_r;
          fnd_nxt  = 1'b0;
          full_nxt = 1'b0;
          if (in_ch.req_type == chm_pkg::REQ_NOP) begin
            state_nxt = chm_pkg::ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = chm_pkg::ST_MOD;
          end
        end
      end
      chm_pkg::ST_MOD: begin
        if (div_done) begin
          b_nxt     = BW'(div_rem);
          state_nxt = chm_pkg::ST_HEAD_RD;
        end
      end
      chm_pkg::ST_HEAD_RD: begin
        h_re      = 1'b1;
        state_nxt = chm_pkg::ST_HEAD;
      end
      chm_pkg::ST_HEAD: begin
        head_nxt  = hvalid_r[b_r] ? h_rdata : NIL;
        cur_nxt   = hvalid_r[b_r] ? h_rdata : NIL;
        prev_nxt  = NIL;
        steps_nxt = '0;
        state_nxt = chm_pkg::ST_WALK;
      end
      chm_pkg::ST_WALK: begin
        if (cur_r >= NIL || steps_r == NIL) begin
          // miss: only a put does anything more
          if (req_r == chm_pkg::REQ_PUT) begin
            if (ft_r == '0) begin
              full_nxt  = 1'b1;
              state_nxt = chm_pkg::ST_DONE;
            end else begin
              s_re      = 1'b1;
              ft_nxt    = ft_dec;
              state_nxt = chm_pkg::ST_POP;
            end
          end else begin
            state_nxt = chm_pkg::ST_DONE;
          end
        end else begin
          e_re      = 1'b1;
          state_nxt = chm_pkg::ST_ENT;
        end
      end
      chm_pkg::ST_ENT: begin
        if (k_rdata == key_r) begin
          fnd_nxt   = 1'b1;
          state_nxt = chm_pkg::ST_DONE;
          priority if (req_r == chm_pkg::REQ_PUT) begin
            v_we    = 1'b1;
            v_waddr = cur_r[AW-1:0];
          end else if (req_r == chm_pkg::REQ_GET) begin
            rd_nxt = v_rdata;
          end else begin
            // remove: unlink, push the entry back on the free stack
            rd_nxt = v_rdata;
            if (prev_r == NIL) begin
              h_we    = 1'b1;
              h_wdata = l_rdata;
            end else begin
              l_we    = 1'b1;
              l_waddr = prev_r[AW-1:0];
              l_wdata = l_rdata;
            end
            if (ft_r < NIL) begin
              s_we   = 1'b1;
              ft_nxt = ft_r + 1'b1;
            end
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = l_rdata;
          steps_nxt = steps_r + 1'b1;
          state_nxt = chm_pkg::ST_WALK;
        end
      end
      chm_pkg::ST_POP: begin
        // new entry goes to the head of its chain
        k_we  = 1'b1;
        v_we  = 1'b1;
        l_we  = 1'b1;
        h_we  = 1'b1;
        h_wdata = LW'(new_e);
        hvalid_nxt[b_r] = 1'b1;
        if (ft_r < low_r) begin
          low_nxt = ft_r;
        end
        if (cnt_r < NIL) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = chm_pkg::ST_DONE;
      end
      chm_pkg::ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ord_nxt   = rd_r;
          ofnd_nxt  = fnd_r;
          ofull_nxt = full_r;
          ocnt_nxt  = chm_pkg::COUNT_W'(cnt_r);
          state_nxt = chm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= chm_pkg::ST_IDLE;
      ft_r     <= NIL;
      low_r    <= NIL;
      cnt_r    <= '0;
      hvalid_r <= '0;
      ov_r     <= 1'b0;
      bc_r     <= chm_pkg::BUCKET_COUNT_RST;
      null_r   <= chm_pkg::NULL_VALUE_RST;
    end else begin
      state_r  <= state_nxt;
      ft_r     <= ft_nxt;
      low_r    <= low_nxt;
      cnt_r    <= cnt_nxt;
      hvalid_r <= hvalid_nxt;
      ov_r     <= ov_nxt;
      if (cfg_ch.valid && cfg_ch.index == chm_pkg::REG_BUCKET_COUNT) begin
        bc_r <= cfg_ch.data[chm_pkg::BC_W-1:0];
      end
      if (cfg_ch.valid && cfg_ch.index == chm_pkg::REG_NULL_VALUE) begin
        null_r <= cfg_ch.data;
      end
    end
    req_r   <= req_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    b_r     <= b_nxt;
    head_r  <= head_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    rd_r    <= rd_nxt;
    fnd_r   <= fnd_nxt;
    full_r  <= full_nxt;
    ord_r   <= ord_nxt;
    ofnd_r  <= ofnd_nxt;
    ofull_r <= ofull_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  // bucket index: hash modulo the effective bucket count
  chm_div #(
    .DIVIDEND_W (KEY_BITS),
    .DIVISOR_W  (NB_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (hash),
    .divisor   (n_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  chm_ram #(.DEPTH(MAX_BUCKETS), .WIDTH(LW)) u_heads (
    .clk (clk), .we (h_we), .waddr (h_waddr), .wdata (h_wdata),
    .re (h_re), .raddr (b_r), .rdata (h_rdata)
  );

  chm_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(KEY_BITS)) u_keys (
    .clk (clk), .we (k_we), .waddr (k_waddr), .wdata (key_r),
    .re (e_re), .raddr (e_raddr), .rdata (k_rdata)
  );

  chm_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(chm_pkg::VALUE_W)) u_values (
    .clk (clk), .we (v_we), .waddr (v_waddr), .wdata (v_wdata),
    .re (e_re), .raddr (e_raddr), .rdata (v_rdata)
  );

  chm_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(LW)) u_links (
    .clk (clk), .we (l_we), .waddr (l_waddr), .wdata (l_wdata),
    .re (e_re), .raddr (e_raddr), .rdata (l_rdata)
  );

  chm_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(AW)) u_free (
    .clk (clk), .we (s_we), .waddr (s_waddr), .wdata (s_wdata),
    .re (s_re), .raddr (s_raddr), .rdata (s_rdata)
  );

  assign in_ch.ready        = (state_r == chm_pkg::ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = ov_r;
  assign out_ch.read_value  = ord_r;
  assign out_ch.found       = ofnd_r;
  assign out_ch.full_error  = ofull_r;
  assign out_ch.entry_count = ocnt_r;

endmodule

// ===== rtl/chm_checker.sv =====
// port-level checks of the chained hash map, bound to the top level
// depends on chained_hash_map_macros.svh and chained_hash_map
`timescale 1ns / 1ps
`include "chained_hash_map_macros.svh"

module chm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [31:0] read_value,
  input logic       found,
  input logic       full_error,
  input logic [8:0] entry_count
);

  `CHM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value), "result beat dropped or changed while stalled")
  `CHM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted while another is at work")
  `CHM_ASSERT_NOW(a_flags_excl, out_valid, !(found && full_error), "found and full_error both set")
  `CHM_ASSERT_NOW(a_full_count, out_valid && full_error, entry_count == 9'd256, "pool full flagged below capacity")

endmodule

bind chained_hash_map chm_checker u_chm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_value  (out_ch.read_value),
  .found       (out_ch.found),
  .full_error  (out_ch.full_error),
  .entry_count (out_ch.entry_count)
);
